[hdl/ocd_pkg.sv]
// ----------------------------------------------------------------------------
// ocd_pkg
// Shared widths, operation and status codes, and controller/datapath types
// for the ordered queue with cancel and demote.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TICKET_BITS = 16;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (TICKET_BITS > 16) ? TICKET_BITS : 16;

  localparam int KIND_W   = 3;
  localparam int WEIGHT_W = 8;
  localparam int TID_W    = 16;
  localparam int STATUS_W = 2;
  localparam int TEAMS_W  = 4;
  localparam int PEOPLE_W = 12;

  localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEMOTE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SERVE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [TICKET_BITS-1:0] ticket;
    logic [WEIGHT_W-1:0]    weight;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_SWAP_RD,
    S_SWAP_WR0,
    S_SWAP_WR1,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                latch;
    logic                res_init;
    logic [STATUS_W-1:0] res_code;
    logic                enq;
    logic                scan_start;
    logic                scan;
    logic                found;
    logic                shift;
    logic                pop;
    logic                swap_wr0;
    logic                swap_wr1;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              lim_zero;
    logic              match;
    logic              scan_end;
    logic              shift_idle;
    logic              out_free;
  } stat_t;

endpackage

[hdl/ocd_if.sv]
// ----------------------------------------------------------------------------
// ocd request and response channels
// Valid/ready channels carrying one operation request and one result.
// ----------------------------------------------------------------------------
interface ocd_req_if import ocd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [WEIGHT_W-1:0] party_size;
  logic [TID_W-1:0]    ticket_id;

  modport source (output valid, kind, party_size, ticket_id, input ready);
  modport sink   (input valid, kind, party_size, ticket_id, output ready);
endinterface

interface ocd_rsp_if import ocd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TID_W-1:0]    ticket_out;
  logic [WEIGHT_W-1:0] weight_out;
  logic [TEAMS_W-1:0]  teams_ahead;
  logic [PEOPLE_W-1:0] people_ahead;

  modport source (output valid, status, ticket_out, weight_out, teams_ahead,
                  people_ahead, input ready);
  modport sink   (input valid, status, ticket_out, weight_out, teams_ahead,
                  people_ahead, output ready);
endinterface

[hdl/ocd_dp.sv]
// ----------------------------------------------------------------------------
// ocd_dp
// Slot memory, occupancy and ticket counters, scan/shift pipeline and the
// result and output registers.
// ----------------------------------------------------------------------------
module ocd_dp import ocd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic [KIND_W-1:0]   req_kind,
  input  logic [WEIGHT_W-1:0] req_party_size,
  input  logic [TID_W-1:0]    req_ticket_id,
  ocd_rsp_if.source         rsp
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata;
  entry_t hold;
  entry_t wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  logic [KIND_W-1:0]      kind;
  logic [WEIGHT_W-1:0]    party;
  logic [TID_W-1:0]       tid;
  logic [CNT_W-1:0]       occ;
  logic [TICKET_BITS-1:0] last_ticket;
  logic [TICKET_BITS-1:0] new_ticket;

  logic [CNT_W-1:0]    idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_vld;
  logic [IDX_W-1:0]    pos;
  logic [PEOPLE_W-1:0] sum;
  logic [PEOPLE_W:0]   sum_add;
  logic [CNT_W-1:0]    lim;
  logic                hit;

  logic [STATUS_W-1:0] res_status;
  logic [TID_W-1:0]    res_tout;
  logic [WEIGHT_W-1:0] res_wout;
  logic [TEAMS_W-1:0]  res_teams;
  logic [PEOPLE_W-1:0] res_people;

  assign new_ticket = last_ticket + TICKET_BITS'(1);
  assign raddr      = idx[IDX_W-1:0];
  assign sum_add    = {1'b0, sum} + (PEOPLE_W+1)'(rdata.weight);

  always_comb begin
    if (kind == KIND_DEMOTE) begin
      lim = (occ == '0) ? '0 : occ - CNT_W'(1);
    end else begin
      lim = occ;
    end
  end

  // serve takes the head whatever its ticket
  assign hit = (kind == KIND_SERVE) ||
               (CMP_W'(rdata.ticket) == CMP_W'(tid));

  assign st.kind       = kind;
  assign st.full       = (occ == CNT_W'(QUEUE_DEPTH));
  assign st.lim_zero   = (lim == '0);
  assign st.match      = rd_vld && hit;
  assign st.scan_end   = rd_vld && !hit && ((CNT_W'(rd_idx) + CNT_W'(1)) == lim);
  assign st.shift_idle = !rd_vld && (idx >= occ);
  assign st.out_free   = !rsp.valid || rsp.ready;

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    if (cmd.enq) begin
      we    = 1'b1;
      waddr = occ[IDX_W-1:0];
      wdata = '{ticket: new_ticket, weight: party};
    end else if (cmd.shift) begin
      we    = rd_vld;
      waddr = rd_idx - IDX_W'(1);
      wdata = rdata;
    end else if (cmd.swap_wr0) begin
      we    = 1'b1;
      waddr = pos;
      wdata = rdata;
    end else if (cmd.swap_wr1) begin
      we    = 1'b1;
      waddr = idx[IDX_W-1:0];
      wdata = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      last_ticket <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cmd.enq) begin
        occ         <= occ + CNT_W'(1);
        last_ticket <= new_ticket;
      end else if (cmd.pop) begin
        occ <= occ - CNT_W'(1);
      end
      if (cmd.load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // request latch, scan pipeline and result fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind  <= req_kind;
      party <= req_party_size;
      tid   <= req_ticket_id;
    end

    if (cmd.res_init) begin
      res_status <= cmd.res_code;
      res_tout   <= cmd.enq ? TID_W'(new_ticket) : '0;
      res_wout   <= '0;
      res_teams  <= '0;
      res_people <= '0;
    end

    if (cmd.scan_start) begin
      idx    <= '0;
      rd_vld <= 1'b0;
      sum    <= '0;
    end else if (cmd.found) begin
      idx    <= CNT_W'(rd_idx) + CNT_W'(1);
      rd_vld <= 1'b0;
      pos    <= rd_idx;
      hold   <= rdata;
      res_status <= ST_OK;
      if (kind == KIND_QUERY) begin
        res_teams  <= (32'(rd_idx) > 32'd15) ? '1 : TEAMS_W'(rd_idx);
        res_people <= sum;
      end
      if (kind == KIND_SERVE) begin
        res_tout <= TID_W'(rdata.ticket);
        res_wout <= rdata.weight;
      end
    end else if (cmd.scan || cmd.shift) begin
      if (idx < (cmd.scan ? lim : occ)) begin
        idx <= idx + CNT_W'(1);
      end
      rd_vld <= (idx < (cmd.scan ? lim : occ));
      rd_idx <= idx[IDX_W-1:0];
      if (cmd.scan && rd_vld) begin
        sum <= sum_add[PEOPLE_W] ? '1 : sum_add[PEOPLE_W-1:0];
      end
    end

    if (cmd.load_out) begin
      rsp.status       <= res_status;
      rsp.ticket_out   <= res_tout;
      rsp.weight_out   <= res_wout;
      rsp.teams_ahead  <= res_teams;
      rsp.people_ahead <= res_people;
    end
  end

endmodule

[hdl/ocd_ctrl.sv]
// ----------------------------------------------------------------------------
// ocd_ctrl
// Operation sequencer: decode, scan for the ticket, then shift or swap the
// slots and hand the result to the output register.
// ----------------------------------------------------------------------------
module ocd_ctrl import ocd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   scan_kind;

  assign scan_kind = (st.kind == KIND_QUERY) || (st.kind == KIND_CANCEL) ||
                     (st.kind == KIND_DEMOTE) || (st.kind == KIND_SERVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (scan_kind && !st.lim_zero) state_next = S_SCAN;
        else state_next = S_FINISH;
      end
      S_SCAN: begin
        if (st.match) begin
          unique case (st.kind)
            KIND_QUERY:  state_next = S_FINISH;
            KIND_DEMOTE: state_next = S_SWAP_RD;
            default:     state_next = S_SHIFT;
          endcase
        end else if (st.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (st.shift_idle) state_next = S_FINISH;
      end
      S_SWAP_RD:  state_next = S_SWAP_WR0;
      S_SWAP_WR0: state_next = S_SWAP_WR1;
      S_SWAP_WR1: state_next = S_FINISH;
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      S_DECODE: begin
        cmd.res_init = 1'b1;
        unique case (st.kind)
          KIND_ENQ: begin
            cmd.res_code = st.full ? ST_FULL : ST_OK;
            cmd.enq      = !st.full;
          end
          KIND_SERVE: begin
            cmd.res_code   = st.lim_zero ? ST_EMPTY : ST_NOTFOUND;
            cmd.scan_start = !st.lim_zero;
          end
          KIND_QUERY, KIND_CANCEL, KIND_DEMOTE: begin
            cmd.res_code   = ST_NOTFOUND;
            cmd.scan_start = !st.lim_zero;
          end
          default: cmd.res_code = ST_NOTFOUND;
        endcase
      end
      S_SCAN: begin
        cmd.scan  = !st.match;
        cmd.found = st.match;
      end
      S_SHIFT: begin
        cmd.pop   = st.shift_idle;
        cmd.shift = !st.shift_idle;
      end
      S_SWAP_WR0: cmd.swap_wr0 = 1'b1;
      S_SWAP_WR1: cmd.swap_wr1 = 1'b1;
      S_FINISH:   cmd.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/ordered_queue_cancel_demote.sv]
// ----------------------------------------------------------------------------
// ordered_queue_cancel_demote
// Ordered waiting queue of ticket/weight entries with enqueue, query, cancel,
// demote and serve.
// ----------------------------------------------------------------------------
// One request is handled at a time. Enqueue, and any request rejected up
// front (full, empty, unknown kind), skips the scan. Query, cancel, demote
// and serve walk the slot memory through its single read port, one entry
// per cycle; cancel and serve then move the entries behind the removed one
// up one slot per cycle, and demote swaps the found entry with the one
// behind it. The result sits in an output register, so a new request is
// taken while the previous result still waits.
module ordered_queue_cancel_demote import ocd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ocd_req_if.sink   req,
  ocd_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t st;
  logic  ready;

  assign req.ready = ready;

  ocd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .st        (st),
    .cmd       (cmd)
  );

  ocd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_kind       (req.kind),
    .req_party_size (req.party_size),
    .req_ticket_id  (req.ticket_id),
    .rsp            (rsp)
  );

endmodule
